// ===== rtl/core/ctb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctb_pkg: shared types and constants of the circular trace buffer
// Request and result records, request kinds and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

  localparam int unsigned CTB_RING_DEPTH  = 4096;
  localparam int unsigned CTB_MAX_CHUNK   = 64;
  localparam int unsigned CTB_QUEUE_DEPTH = 4;
  localparam int unsigned CTB_QPTR_W      = $clog2(CTB_QUEUE_DEPTH);

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 64;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned BUF_W    = 13;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 152;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_e;

  typedef struct packed {
    req_kind_e             kind;
    logic [BYTE_W-1:0]     wbyte;
    logic                  line_end;
    logic [OFFSET_W-1:0]   offset;
    logic [LEN_W-1:0]      len;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_byte;
    logic                data_valid;
    logic                last;
    logic [OFFSET_W-1:0] next_offset;
    logic [OFFSET_W-1:0] total_bytes;
    logic [BUF_W-1:0]    buffered_bytes;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/circular_trace_buffer.sv =====
// ----------------------------------------------------------------------------
// circular_trace_buffer: log trace ring with absolute stream offsets
// Keeps the newest RING_DEPTH log bytes and serves reads by 64-bit offset.
// ----------------------------------------------------------------------------
// Requests enter through a four-entry queue, so intake keeps taking requests
// while the execution unit works or the result register waits. The execution
// unit takes one write or clear per cycle while no read is in progress; a read
// first clamps its offset into the window (a 64-bit subtract, the clamp to the
// kept bytes, the start and the next offset) and then returns one byte per
// cycle from the ring's single read port while the result register is free.
// A write that ends a line, and a clear, wait for a free result register. The
// ring has no reset and needs no clearing pass: reads only reach bytes written
// since the window last restarted. A write to the capture register restarts
// the window empty; the register port is always ready, so write it only while
// no request is queued, executing or waiting as a result.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_trace_buffer #(
  parameter int unsigned RING_DEPTH = ctb_pkg::CTB_RING_DEPTH,
  parameter int unsigned MAX_CHUNK  = ctb_pkg::CTB_MAX_CHUNK
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // capture enable register
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic                             cfg_data_i,
  // request stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // write_byte[7:0], read_offset[71:8], max_length[78:72], zero [79]
  input  wire logic [ctb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                             s_axis_tlast,   // line_end
  input  wire logic [1:0]                       s_axis_tuser,   // req_type[1:0]
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // data_byte[7:0], next_offset[71:8], total_bytes[135:72],
  // buffered_bytes[148:136], zero [151:149]
  output logic [ctb_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tlast,   // last
  output logic [0:0]                            m_axis_tuser    // data_valid[0]
);
  import ctb_pkg::*;

  logic push;
  logic full;
  req_t push_req;
  logic q_valid;
  req_t q_req;
  logic q_pop;
  res_t res;

  assign cfg_ready_o = 1'b1;

  ctb_front #(
    .MAX_CHUNK(MAX_CHUNK)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .full_i       (full),
    .push_o       (push),
    .req_o        (push_req)
  );

  ctb_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_req_i(push_req),
    .full_o    (full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .req_o     (q_req)
  );

  ctb_exec #(
    .RING_DEPTH(RING_DEPTH)
  ) u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .q_valid_i  (q_valid),
    .q_req_i    (q_req),
    .q_pop_o    (q_pop),
    .res_valid_o(m_axis_tvalid),
    .res_o      (res),
    .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {3'b000, res.buffered_bytes, res.total_bytes,
                         res.next_offset, res.data_byte};
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.data_valid;

endmodule

`default_nettype wire

// ===== rtl/core/ctb_front.sv =====
// ----------------------------------------------------------------------------
// ctb_front: request intake
// Unpacks the stream, decodes the request kind, saturates the read length
// and pushes useful requests into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_front #(
  parameter int unsigned MAX_CHUNK = ctb_pkg::CTB_MAX_CHUNK
) (
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [ctb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                            s_axis_tlast,
  input  wire logic [1:0]                      s_axis_tuser,
  input  wire logic                            full_i,
  output logic                                 push_o,
  output ctb_pkg::req_t                        req_o
);
  import ctb_pkg::*;

  logic [LEN_W-1:0] len_raw;

  assign len_raw = s_axis_tdata[78:72];

  always_comb begin
    req_o.kind     = req_kind_e'(s_axis_tuser);
    req_o.wbyte    = s_axis_tdata[7:0];
    req_o.line_end = s_axis_tlast;
    req_o.offset   = s_axis_tdata[71:8];
    req_o.len      = (len_raw > LEN_W'(MAX_CHUNK)) ? LEN_W'(MAX_CHUNK) : len_raw;
  end

  assign s_axis_tready = !full_i;
  // drop the unused kind here, it has no effect and no result
  assign push_o = s_axis_tvalid && !full_i && (req_o.kind != REQ_NONE);

endmodule

`default_nettype wire

// ===== rtl/core/ctb_fifo.sv =====
// ----------------------------------------------------------------------------
// ctb_fifo: request queue
// Short first-in first-out queue between intake and execution.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  ctb_pkg::req_t      push_req_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output ctb_pkg::req_t      req_o
);
  import ctb_pkg::*;

  req_t                  entry_q [CTB_QUEUE_DEPTH];
  logic [CTB_QPTR_W-1:0] wptr_q, wptr_d;
  logic [CTB_QPTR_W-1:0] rptr_q, rptr_d;
  logic [CTB_QPTR_W:0]   cnt_q, cnt_d;
  logic                  do_pop;

  assign full_o  = (cnt_q == (CTB_QPTR_W+1)'(CTB_QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign req_o   = entry_q[rptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_req_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ctb_exec.sv =====
// ----------------------------------------------------------------------------
// ctb_exec: request execution
// Holds the running total, the window fill and the ring memory; carries out
// writes, reads and clears and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_exec #(
  parameter int unsigned RING_DEPTH = ctb_pkg::CTB_RING_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic       cfg_data_i,
  input  wire logic       q_valid_i,
  input  ctb_pkg::req_t   q_req_i,
  output logic            q_pop_o,
  output logic            res_valid_o,
  output ctb_pkg::res_t   res_o,
  input  wire logic       res_ready_i
);
  import ctb_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned DW = AW + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLAMP  = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_NEXT   = 3'd3;
  localparam logic [2:0] ST_STREAM = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [OFFSET_W-1:0] total_q, total_d;
  logic [DW-1:0]       fill_q, fill_d;
  logic [AW-1:0]       wptr_q, wptr_d;
  logic                cap_q, cap_d;
  logic [LEN_W-1:0]    cnt_q, cnt_d;
  logic                out_valid_q;

  logic [OFFSET_W:0]   diff_q, diff_d;
  logic [DW-1:0]       dist_q, dist_d;
  logic [OFFSET_W-1:0] start_q, start_d;
  logic [OFFSET_W-1:0] next_q, next_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  res_t                res_q, res_d;

  logic [BYTE_W-1:0]   ring_q [RING_DEPTH];
  logic [BYTE_W-1:0]   rdata_q;

  logic                out_free;
  logic                load;
  logic                mem_we;
  logic [DW-1:0]       fill_inc;
  logic [AW-1:0]       wptr_inc;
  logic [AW-1:0]       rd_ptr_inc;
  logic [DW-1:0]       wptr_ext;
  logic [DW-1:0]       pos_full;

  function automatic logic [BUF_W-1:0] buf_of(input logic cap, input logic [DW-1:0] fill);
    return cap ? BUF_W'(fill) : '0;
  endfunction

  assign out_free    = !out_valid_q || res_ready_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign fill_inc   = (fill_q == DW'(RING_DEPTH)) ? fill_q : fill_q + 1'b1;
  assign wptr_inc   = (wptr_q == AW'(RING_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
  assign rd_ptr_inc = (rd_ptr_q == AW'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign wptr_ext   = {1'b0, wptr_q};
  // ring slot of the clamped start: write pointer minus distance, modulo depth
  assign pos_full   = (wptr_ext >= dist_q) ? wptr_ext - dist_q
                                           : wptr_ext + DW'(RING_DEPTH) - dist_q;

  always_comb begin
    state_d  = state_q;
    total_d  = total_q;
    fill_d   = fill_q;
    wptr_d   = wptr_q;
    cap_d    = cap_q;
    cnt_d    = cnt_q;
    diff_d   = diff_q;
    dist_d   = dist_q;
    start_d  = start_q;
    next_d   = next_q;
    len_d    = len_q;
    rd_ptr_d = rd_ptr_q;
    res_d    = res_q;
    load     = 1'b0;
    mem_we   = 1'b0;
    q_pop_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_req_i.kind)
            REQ_WRITE: begin
              if (!q_req_i.line_end || out_free) begin
                q_pop_o = 1'b1;
                mem_we  = cap_q;
                total_d = total_q + 1'b1;
                wptr_d  = wptr_inc;
                fill_d  = fill_inc;
                if (q_req_i.line_end) begin
                  load                 = 1'b1;
                  res_d.data_byte      = '0;
                  res_d.data_valid     = 1'b0;
                  res_d.last           = 1'b1;
                  res_d.next_offset    = '0;
                  res_d.total_bytes    = total_d;
                  res_d.buffered_bytes = buf_of(cap_q, fill_inc);
                end
              end
            end
            REQ_READ: begin
              if (!cap_q || q_req_i.len == '0) begin
                if (out_free) begin
                  q_pop_o              = 1'b1;
                  load                 = 1'b1;
                  res_d.data_byte      = '0;
                  res_d.data_valid     = 1'b0;
                  res_d.last           = 1'b1;
                  res_d.next_offset    = q_req_i.offset;
                  res_d.total_bytes    = total_q;
                  res_d.buffered_bytes = buf_of(cap_q, fill_q);
                end
              end else begin
                q_pop_o = 1'b1;
                // borrow bit marks an offset beyond the total
                diff_d  = {1'b0, total_q} - {1'b0, q_req_i.offset};
                len_d   = q_req_i.len;
                state_d = ST_CLAMP;
              end
            end
            REQ_CLEAR: begin
              if (out_free) begin
                q_pop_o              = 1'b1;
                fill_d               = '0;
                load                 = 1'b1;
                res_d.data_byte      = '0;
                res_d.data_valid     = 1'b0;
                res_d.last           = 1'b1;
                res_d.next_offset    = '0;
                res_d.total_bytes    = total_q;
                res_d.buffered_bytes = '0;
              end
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_CLAMP: begin
        // distance back from the total, limited to the kept bytes
        if (diff_q[OFFSET_W]) begin
          dist_d = '0;
        end else if (diff_q[OFFSET_W-1:0] > OFFSET_W'(fill_q)) begin
          dist_d = fill_q;
        end else begin
          dist_d = diff_q[DW-1:0];
        end
        state_d = ST_START;
      end
      ST_START: begin
        start_d  = total_q - OFFSET_W'(dist_q);
        cnt_d    = (OFFSET_W'(dist_q) > OFFSET_W'(len_q)) ? len_q : LEN_W'(dist_q);
        rd_ptr_d = pos_full[AW-1:0];
        state_d  = ST_NEXT;
      end
      ST_NEXT: begin
        next_d  = start_q + OFFSET_W'(cnt_q);
        state_d = ST_STREAM;
      end
      ST_STREAM: begin
        if (out_free) begin
          load                 = 1'b1;
          res_d.next_offset    = next_q;
          res_d.total_bytes    = total_q;
          res_d.buffered_bytes = buf_of(cap_q, fill_q);
          if (cnt_q == '0) begin
            res_d.data_byte  = '0;
            res_d.data_valid = 1'b0;
            res_d.last       = 1'b1;
            state_d          = ST_IDLE;
          end else begin
            res_d.data_byte  = rdata_q;
            res_d.data_valid = 1'b1;
            res_d.last       = (cnt_q == LEN_W'(1));
            cnt_d            = cnt_q - 1'b1;
            rd_ptr_d         = rd_ptr_inc;
            if (cnt_q == LEN_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // restart the window on any capture setting write
    if (cfg_valid_i) begin
      cap_d  = cfg_data_i;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      fill_q      <= '0;
      wptr_q      <= '0;
      cap_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      fill_q  <= fill_d;
      wptr_q  <= wptr_d;
      cap_q   <= cap_d;
      cnt_q   <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q   <= diff_d;
    dist_q   <= dist_d;
    start_q  <= start_d;
    next_q   <= next_d;
    len_q    <= len_d;
    rd_ptr_q <= rd_ptr_d;
    if (load) begin
      res_q <= res_d;
    end
  end

  // ring memory: one write port, one registered read port that follows the
  // next read pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[wptr_q] <= q_req_i.wbyte;
    end
    rdata_q <= ring_q[rd_ptr_d];
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: circular trace buffer testbench
// Sends directed and random write, read and clear requests over the request
// stream. A scoreboard keeps its own copy of the ring, the window and the
// running total, predicts every result, and checks the result stream field
// by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_top;
  import ctb_pkg::*;

  localparam int unsigned DEPTH           = CTB_RING_DEPTH;
  localparam int unsigned CHUNK           = CTB_MAX_CHUNK;
  localparam int unsigned IDLE_PCT        = 18;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = 32;
  localparam int unsigned ITEMS_PER_PHASE = 40;
  localparam int unsigned NUM_PHASES      = 6;

  class trace_scoreboard;
    bit [7:0]    ring_copy [DEPTH];
    bit [63:0]   total_count;
    bit [63:0]   window_start;
    bit          capture_on;
    res_t        trace_results_q [$];
    int unsigned error_count;
    int unsigned checked_count;

    function int pending();
      return trace_results_q.size();
    endfunction

    function bit [63:0] oldest_kept();
      if (total_count - window_start > 64'(DEPTH)) return total_count - 64'(DEPTH);
      return window_start;
    endfunction

    function bit [12:0] buffered_now();
      bit [63:0] avail;
      if (!capture_on) return '0;
      avail = total_count - window_start;
      if (avail > 64'(DEPTH)) avail = 64'(DEPTH);
      return avail[12:0];
    endfunction

    function void push_result(bit [7:0] data, bit valid, bit fin, bit [63:0] next);
      res_t r;
      r.data_byte      = data;
      r.data_valid     = valid;
      r.last           = fin;
      r.next_offset    = next;
      r.total_bytes    = total_count;
      r.buffered_bytes = buffered_now();
      trace_results_q.push_back(r);
    endfunction

    // Any capture write restarts the window empty.
    function void set_capture(bit value);
      capture_on   = value;
      window_start = total_count;
    endfunction

    function void note_request(req_t rq);
      bit [63:0] start;
      bit [63:0] avail;
      bit [63:0] count;
      bit [63:0] i;
      bit [6:0]  span;
      case (rq.kind)
        REQ_WRITE: begin
          if (capture_on) ring_copy[total_count % 64'(DEPTH)] = rq.wbyte;
          total_count++;
          if (rq.line_end) push_result(8'h00, 1'b0, 1'b1, 64'd0);
        end
        REQ_READ: begin
          span = (rq.len > 7'(CHUNK)) ? 7'(CHUNK) : rq.len;
          if (!capture_on || span == 7'd0) begin
            push_result(8'h00, 1'b0, 1'b1, rq.offset);
          end else begin
            start = (rq.offset > total_count) ? total_count : rq.offset;
            if (start < oldest_kept()) start = oldest_kept();
            avail = total_count - start;
            count = (avail < 64'(span)) ? avail : 64'(span);
            if (count == 64'd0) begin
              push_result(8'h00, 1'b0, 1'b1, start);
            end else begin
              for (i = 64'd0; i < count; i++) begin
                push_result(ring_copy[(start + i) % 64'(DEPTH)], 1'b1,
                            (i + 64'd1) == count, start + count);
              end
            end
          end
        end
        REQ_CLEAR: begin
          window_start = total_count;
          push_result(8'h00, 1'b0, 1'b1, 64'd0);
        end
        default: ;  // drop the unused request kind
      endcase
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        error_count++;
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (trace_results_q.size() == 0) begin
        error_count++;
        $error("unexpected result: data_byte 0x%0h next_offset 0x%0h total_bytes 0x%0h",
               got.data_byte, got.next_offset, got.total_bytes);
        return;
      end
      want = trace_results_q.pop_front();
      checked_count++;
      check_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
      check_field("data_valid", 64'(want.data_valid), 64'(got.data_valid));
      check_field("last", 64'(want.last), 64'(got.last));
      check_field("next_offset", want.next_offset, got.next_offset);
      check_field("total_bytes", want.total_bytes, got.total_bytes);
      check_field("buffered_bytes", 64'(want.buffered_bytes), 64'(got.buffered_bytes));
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_data_i    = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic [1:0]             s_axis_tuser  = 2'd0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic [0:0]             m_axis_tuser;

  trace_scoreboard sb;
  res_t            trace_seen;
  bit              idle_on  = 1'b1;
  bit              hold_off = 1'b0;
  int unsigned     items_sent;
  int unsigned     cfg_writes;
  int unsigned     holds_done;

  circular_trace_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic req_t make_req(req_kind_e kind, logic [7:0] wbyte, logic line_end,
                                    logic [63:0] offset, logic [6:0] len);
    req_t rq;
    rq.kind     = kind;
    rq.wbyte    = wbyte;
    rq.line_end = line_end;
    rq.offset   = offset;
    rq.len      = len;
    return rq;
  endfunction

  // Writes; reads mostly at the live window, fully random offsets as noise.
  function automatic req_t random_req(int unsigned line_odds);
    req_t        rq;
    int unsigned pick;
    logic [63:0] lo;
    pick = $urandom_range(99);
    rq = make_req(REQ_WRITE, 8'($urandom), $urandom_range(line_odds - 1) == 0,
                  {$urandom, $urandom}, 7'($urandom));
    if (pick >= 48 && pick < 88) begin
      rq.kind = REQ_READ;
      lo = sb.oldest_kept();
      case ($urandom_range(9))
        0, 1: ;
        2: rq.offset = sb.total_count + 64'($urandom_range(0, 3));
        default: rq.offset = lo - 64'd4
                   + 64'($urandom_range(0, 32'(sb.total_count - lo) + 8));
      endcase
      case ($urandom_range(9))
        0: rq.len = 7'd0;
        1: rq.len = 7'($urandom_range(CHUNK + 1, 127));
        default: rq.len = 7'($urandom_range(1, CHUNK));
      endcase
    end else if (pick >= 88 && pick < 96) begin
      rq.kind = REQ_CLEAR;
    end else if (pick >= 96) begin
      rq.kind = REQ_NONE;
    end
    return rq;
  endfunction

  task automatic send_item(input req_t rq);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.kind;
    s_axis_tlast  <= rq.line_end;
    s_axis_tdata  <= {1'b0, rq.len, rq.offset, rq.wbyte};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(rq);
    items_sent++;
  endtask

  // Hold the request side until every result is in, then let writes settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capture(input logic value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_capture(value);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      trace_seen.data_byte      = m_axis_tdata[7:0];
      trace_seen.next_offset    = m_axis_tdata[71:8];
      trace_seen.total_bytes    = m_axis_tdata[135:72];
      trace_seen.buffered_bytes = m_axis_tdata[148:136];
      trace_seen.data_valid     = m_axis_tuser[0];
      trace_seen.last           = m_axis_tlast;
      sb.check_result(trace_seen);
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
        holds_done++;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // capture off after reset: totals advance, reads keep their offset
    send_item(make_req(REQ_WRITE, 8'hA5, 1'b1, 64'd0, 7'd0));
    send_item(make_req(REQ_WRITE, 8'h5A, 1'b0, 64'd0, 7'd0));
    send_item(make_req(REQ_READ, 8'h00, 1'b0, '1, 7'd64));
    send_item(make_req(REQ_CLEAR, 8'h00, 1'b0, 64'd0, 7'd0));
    send_item(make_req(REQ_NONE, 8'hFF, 1'b1, '1, 7'd127));

    write_capture(1'b1);
    send_item(make_req(REQ_WRITE, 8'h00, 1'b0, '1, 7'd127));
    send_item(make_req(REQ_WRITE, 8'hFF, 1'b0, 64'd0, 7'd0));
    send_item(make_req(REQ_WRITE, 8'h3C, 1'b1, 64'd0, 7'd0));
    send_item(make_req(REQ_READ, 8'h00, 1'b0, 64'd0, 7'd0));
    send_item(make_req(REQ_READ, 8'hFF, 1'b1, 64'd0, 7'd127));
    send_item(make_req(REQ_READ, 8'h00, 1'b0, '1, 7'd64));
    send_item(make_req(REQ_READ, 8'h00, 1'b0, 64'd3, 7'd1));
    send_item(make_req(REQ_CLEAR, 8'h00, 1'b0, 64'd0, 7'd0));
    send_item(make_req(REQ_READ, 8'h00, 1'b0, 64'd0, 7'd64));
    send_item(make_req(REQ_WRITE, 8'h81, 1'b0, 64'd0, 7'd0));
    send_item(make_req(REQ_WRITE, 8'h7E, 1'b1, 64'd0, 7'd0));
    send_item(make_req(REQ_READ, 8'h00, 1'b0, 64'd0, 7'd64));
    send_item(make_req(REQ_READ, 8'h00, 1'b0, 64'd6, 7'd2));
    send_item(make_req(REQ_NONE, 8'h00, 1'b0, 64'd0, 7'd1));

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capture(p != 1 && p != 4);
      idle_on = (p != 2);
      if (p == 3) hold_off = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 4 && n == ITEMS_PER_PHASE / 2) wait_idle();
        send_item(random_req(4));
      end
    end

    wait_idle();
    $display("Sent %0d requests mixing writes, clamped reads and clears, checked %0d results.",
             items_sent, sb.checked_count);
    $display("Wrote the capture register %0d times, held the result side %0d time(s).",
             cfg_writes, holds_done);
    if (sb.error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== circular_trace_buffer.f =====
rtl/core/ctb_pkg.sv
rtl/core/ctb_front.sv
rtl/core/ctb_fifo.sv
rtl/core/ctb_exec.sv
rtl/core/circular_trace_buffer.sv
dv/tb_top.sv
